### rtl/fat_chain_engine_core_assert.svh
// Assertion macros for the FAT chain engine.
`ifndef FAT_CHAIN_ENGINE_CORE_ASSERT_SVH
`define FAT_CHAIN_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fce_pkg.sv
// Types and constants shared by the FAT chain engine.
package fce_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned OFF_W      = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BLOCKS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_BLOCKS  = 4'd1;

  localparam logic [12:0] DBC_RESET = 13'd4096;
  localparam logic [7:0]  FBC_RESET = 8'd2;

  localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
  localparam logic [15:0] FREE_ENTRY   = 16'h0000;
  localparam logic [15:0] DATA_BASE    = 16'd2;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_WALK  = 3'd2,
    OP_ALLOC = 3'd3,
    OP_FREE  = 3'd4,
    OP_COUNT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_LOOP      = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [15:0]      entry_index;
    logic [15:0]      entry_data;
    logic [OFF_W-1:0] byte_offset;
    logic             link_enable;
    logic [11:0]      previous_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_index;
    logic [15:0] absolute_block;
    logic [15:0] read_value;
    logic [12:0] tally;
    logic        chain_ended;
  } out_t;

endpackage

### rtl/fat_chain_engine_core.sv
// FAT chain engine: table memory and the sequencer that walks, scans and frees it.
// Walk and free follow the chain entry by entry (a free also stops at the loop limit);
// allocate scans up to the first free entry, or over the data block count when none is
// free; count free scans the data block count (clamped to the table size). One item at a
// time, taken once the previous result is queued. Reset clears control and loads the
// configuration defaults.
module fat_chain_engine_core #(
  parameter int FAT_ENTRIES = 4096,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fce_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fce_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fce_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fce_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import fce_pkg::*;

  `include "fat_chain_engine_core_assert.svh"

  localparam int unsigned IDX_W = $clog2(FAT_ENTRIES);
  localparam int unsigned CNT_W = $clog2(FAT_ENTRIES + 1);
  localparam logic [16:0]      FE_IDX = 17'(FAT_ENTRIES);
  localparam logic [CNT_W-1:0] FE_CNT = CNT_W'(FAT_ENTRIES);
  localparam logic [OFF_W-1:0] BB_C   = OFF_W'(BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_WALK, S_ASCAN, S_ALINK, S_AMARK, S_FREE, S_COUNT, S_RESP
  } state_e;

  state_e           state_q, state_d;
  logic             link_q, link_d;
  logic [11:0]      prev_q, prev_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [OFF_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic             chk_q, chk_d;
  status_e          status_q, status_d;
  logic [15:0]      found_q, found_d;
  logic             abs_en_q, abs_en_d;
  logic             tally_en_q, tally_en_d;
  logic [15:0]      rval_q, rval_d;
  logic             ended_q, ended_d;
  logic [12:0]      dbc_q, dbc_d;
  logic [7:0]       fbc_q, fbc_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic [15:0]      fat_q [FAT_ENTRIES];
  logic [15:0]      rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata;

  logic             in_idx_ok, in_start_ok, nxt_ok;
  logic [OFF_W-1:0] rem_sub;
  logic [CNT_W-1:0] lim_calc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_idx_ok   = ({1'b0, in_data_i.entry_index} < FE_IDX);
  assign in_start_ok = in_idx_ok && (in_data_i.entry_index != END_OF_CHAIN);
  assign nxt_ok      = ({1'b0, rdata_q} < FE_IDX);
  assign rem_sub     = rem_q - BB_C;
  assign lim_calc    = (17'(dbc_q) < FE_IDX) ? CNT_W'(dbc_q) : FE_CNT;

  // table memory, write-through on a same-address read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fat_q[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      rdata_q <= mem_wdata;
    end else begin
      rdata_q <= fat_q[mem_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    link_d      = link_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    lim_d       = lim_q;
    chk_d       = chk_q;
    status_d    = status_q;
    found_d     = found_q;
    abs_en_d    = abs_en_q;
    tally_en_d  = tally_en_q;
    rval_d      = rval_q;
    ended_d     = ended_q;
    dbc_d       = dbc_q;
    fbc_d       = fbc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = FREE_ENTRY;
    mem_raddr   = cur_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DATA_BLOCKS: dbc_d = cfg_data_i;
        CFG_FAT_BLOCKS:  fbc_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = in_data_i.entry_index[IDX_W-1:0];
        if (in_valid_i) begin
          link_d     = in_data_i.link_enable;
          prev_d     = in_data_i.previous_index;
          rem_d      = in_data_i.byte_offset;
          cur_d      = in_data_i.entry_index[IDX_W-1:0];
          cnt_d      = '0;
          chk_d      = 1'b0;
          lim_d      = lim_calc;
          status_d   = ST_OK;
          found_d    = '0;
          abs_en_d   = 1'b0;
          tally_en_d = 1'b0;
          rval_d     = '0;
          ended_d    = 1'b0;
          state_d    = S_RESP;
          unique case (in_data_i.opcode)
            OP_WRITE: begin
              if (in_idx_ok) begin
                mem_we    = 1'b1;
                mem_waddr = in_data_i.entry_index[IDX_W-1:0];
                mem_wdata = in_data_i.entry_data;
              end else begin
                status_d = ST_BAD_INDEX;
              end
            end
            OP_READ: begin
              if (in_idx_ok) begin
                state_d = S_READ;
              end else begin
                status_d = ST_BAD_INDEX;
              end
            end
            OP_WALK: begin
              if (in_start_ok) begin
                found_d  = in_data_i.entry_index;
                abs_en_d = 1'b1;
                if (in_data_i.byte_offset >= BB_C) begin
                  state_d = S_WALK;
                end
              end else begin
                status_d = ST_BAD_INDEX;
              end
            end
            OP_ALLOC: begin
              scan_d  = CNT_W'(1);
              state_d = S_ASCAN;
            end
            OP_FREE: begin
              tally_en_d = 1'b1;
              if (in_start_ok) begin
                state_d = S_FREE;
              end else begin
                status_d = ST_BAD_INDEX;
              end
            end
            OP_COUNT: begin
              tally_en_d = 1'b1;
              scan_d     = '0;
              state_d    = S_COUNT;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        rval_d  = rdata_q;
        state_d = S_RESP;
      end
      S_WALK: begin
        if (rdata_q == END_OF_CHAIN) begin
          ended_d = 1'b1;
          state_d = S_RESP;
        end else if (cnt_q >= FE_CNT) begin
          status_d = ST_LOOP;
          state_d  = S_RESP;
        end else if (!nxt_ok) begin
          status_d = ST_BAD_INDEX;
          state_d  = S_RESP;
        end else begin
          cur_d     = rdata_q[IDX_W-1:0];
          found_d   = rdata_q;
          rem_d     = rem_sub;
          cnt_d     = cnt_q + 1'b1;
          mem_raddr = rdata_q[IDX_W-1:0];
          if (rem_sub < BB_C) begin
            state_d = S_RESP;
          end
        end
      end
      S_ASCAN: begin
        mem_raddr = scan_q[IDX_W-1:0];
        if (chk_q && (rdata_q == FREE_ENTRY)) begin
          found_d  = 16'(scan_q - 1'b1);
          abs_en_d = 1'b1;
          state_d  = S_ALINK;
        end else if (scan_q >= lim_q) begin
          status_d = ST_NO_FREE;
          state_d  = S_RESP;
        end else begin
          scan_d = scan_q + 1'b1;
          chk_d  = 1'b1;
        end
      end
      S_ALINK: begin
        if (link_q && (17'(prev_q) < FE_IDX)) begin
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(prev_q);
          mem_wdata = found_q;
        end
        state_d = S_AMARK;
      end
      S_AMARK: begin
        mem_we    = 1'b1;
        mem_waddr = found_q[IDX_W-1:0];
        mem_wdata = END_OF_CHAIN;
        state_d   = S_RESP;
      end
      S_FREE: begin
        if (cnt_q >= FE_CNT) begin
          status_d = ST_LOOP;
          state_d  = S_RESP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_q;
          mem_wdata = FREE_ENTRY;
          cnt_d     = cnt_q + 1'b1;
          if (rdata_q == END_OF_CHAIN) begin
            state_d = S_RESP;
          end else if (!nxt_ok) begin
            status_d = ST_BAD_INDEX;
            state_d  = S_RESP;
          end else begin
            cur_d     = rdata_q[IDX_W-1:0];
            mem_raddr = rdata_q[IDX_W-1:0];
          end
        end
      end
      S_COUNT: begin
        mem_raddr = scan_q[IDX_W-1:0];
        if (chk_q && (rdata_q == FREE_ENTRY)) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (scan_q >= lim_q) begin
          state_d = S_RESP;
        end else begin
          scan_d = scan_q + 1'b1;
          chk_d  = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.status         = status_q;
          out_d.found_index    = found_q;
          out_d.absolute_block = abs_en_q ? (found_q + DATA_BASE + 16'(fbc_q)) : '0;
          out_d.read_value     = rval_q;
          out_d.tally          = tally_en_q ? 13'(cnt_q) : '0;
          out_d.chain_ended    = ended_q;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      link_q      <= 1'b0;
      prev_q      <= '0;
      cur_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      lim_q       <= '0;
      chk_q       <= 1'b0;
      status_q    <= ST_OK;
      found_q     <= '0;
      abs_en_q    <= 1'b0;
      tally_en_q  <= 1'b0;
      rval_q      <= '0;
      ended_q     <= 1'b0;
      dbc_q       <= DBC_RESET;
      fbc_q       <= FBC_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      link_q      <= link_d;
      prev_q      <= prev_d;
      cur_q       <= cur_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      lim_q       <= lim_d;
      chk_q       <= chk_d;
      status_q    <= status_d;
      found_q     <= found_d;
      abs_en_q    <= abs_en_d;
      tally_en_q  <= tally_en_d;
      rval_q      <= rval_d;
      ended_q     <= ended_d;
      dbc_q       <= dbc_d;
      fbc_q       <= fbc_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `FCE_ASSERT_IMPL(a_scan_no_write, state_q == S_ASCAN || state_q == S_COUNT, !mem_we,
                   "table written during a scan")
  `FCE_ASSERT_IMPL(a_cnt_bound, state_q != S_IDLE, cnt_q <= FE_CNT,
                   "link or entry count beyond table size")
  `FCE_ASSERT_IMPL(a_out_from_resp, $rose(out_valid_q), $past(state_q) == S_RESP,
                   "result raised outside the response state")
  `FCE_ASSERT_NEXT(a_link_then_mark, state_q == S_ALINK, state_q == S_AMARK && mem_we,
                   "allocated entry not marked end of chain")

endmodule

### tb/tb_fat_chain_engine_core.sv
// Self-checking testbench for fat_chain_engine_core: table load, chain ops, config sweep.
`timescale 1ns / 1ps

module tb_fat_chain_engine_core;
  import fce_pkg::*;

  localparam int FAT_N = 4096;
  localparam int BLOCK_N = 4096;
  localparam int MAX_GAP = 10;
  localparam int MAX_STALL = 8;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  out_t out_data;
  logic cfg_ready;

  fat_chain_engine_core #(
    .FAT_ENTRIES(FAT_N),
    .BLOCK_BYTES(BLOCK_N)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow table and registers
  logic [15:0] fat_model [FAT_N];
  logic [12:0] dbc_model = DBC_RESET;
  logic [7:0] fbc_model = FBC_RESET;
  int op_span;

  out_t pending_results [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int config_count = 0;
  int op_seen [8];
  int status_seen [4];
  int burst_left = 0;
  longint cycles = 0;
  longint cycle_budget = 20000;

  // Open files built by the traffic generator
  int file_head [$];
  int file_tail [$];
  int file_len [$];
  int node_total = 0;

  function automatic out_t fat_op_result(in_t it);
    out_t r;
    logic [15:0] cur;
    logic [15:0] nxt;
    int steps;
    int taken;
    int cnt;
    int lim;
    int i;
    r = '0;
    op_span = 1;
    lim = (int'(dbc_model) < FAT_N) ? int'(dbc_model) : FAT_N;
    case (it.opcode)
      OP_WRITE: begin
        if (it.entry_index < FAT_N) fat_model[it.entry_index[11:0]] = it.entry_data;
        else r.status = ST_BAD_INDEX;
      end
      OP_READ: begin
        if (it.entry_index < FAT_N) r.read_value = fat_model[it.entry_index[11:0]];
        else r.status = ST_BAD_INDEX;
      end
      OP_WALK: begin
        if (it.entry_index == END_OF_CHAIN || it.entry_index >= FAT_N) begin
          r.status = ST_BAD_INDEX;
        end else begin
          steps = it.byte_offset / BLOCK_N;
          taken = 0;
          cur = it.entry_index;
          while (steps > 0) begin
            nxt = fat_model[cur[11:0]];
            if (nxt == END_OF_CHAIN) begin
              r.chain_ended = 1'b1;
              break;
            end
            if (taken >= FAT_N) begin
              r.status = ST_LOOP;
              break;
            end
            if (nxt >= FAT_N) begin
              r.status = ST_BAD_INDEX;
              break;
            end
            cur = nxt;
            steps--;
            taken++;
          end
          r.found_index = cur;
          r.absolute_block = cur + DATA_BASE + 16'(fbc_model);
          op_span = taken + 3;
        end
      end
      OP_ALLOC: begin
        i = 1;
        while (i < lim && fat_model[i[11:0]] != FREE_ENTRY) i++;
        if (i >= lim) begin
          r.status = ST_NO_FREE;
        end else begin
          if (it.link_enable) fat_model[it.previous_index] = 16'(i);
          fat_model[i[11:0]] = END_OF_CHAIN;
          r.found_index = 16'(i);
          r.absolute_block = 16'(i) + DATA_BASE + 16'(fbc_model);
        end
        op_span = i + 4;
      end
      OP_FREE: begin
        if (it.entry_index == END_OF_CHAIN || it.entry_index >= FAT_N) begin
          r.status = ST_BAD_INDEX;
        end else begin
          cur = it.entry_index;
          cnt = 0;
          while (cur != END_OF_CHAIN) begin
            if (cur >= FAT_N) begin
              r.status = ST_BAD_INDEX;
              break;
            end
            if (cnt >= FAT_N) begin
              r.status = ST_LOOP;
              break;
            end
            nxt = fat_model[cur[11:0]];
            fat_model[cur[11:0]] = FREE_ENTRY;
            cnt++;
            cur = nxt;
          end
          r.tally = 13'(cnt);
          op_span = cnt + 3;
        end
      end
      OP_COUNT: begin
        cnt = 0;
        for (i = 0; i < lim; i++) if (fat_model[i[11:0]] == FREE_ENTRY) cnt++;
        r.tally = 13'(cnt);
        op_span = lim + 4;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_t make_item(logic [2:0] op, logic [15:0] idx, logic [15:0] data,
                                    logic [23:0] boff, logic link, logic [11:0] prev);
    in_t it;
    it.opcode = op;
    it.entry_index = idx;
    it.entry_data = data;
    it.byte_offset = boff;
    it.link_enable = link;
    it.previous_index = prev;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t it;
    it.opcode = 3'($urandom_range(0, 7));
    it.entry_index = 16'($urandom);
    it.entry_data = 16'($urandom);
    it.byte_offset = 24'($urandom);
    it.link_enable = 1'($urandom);
    it.previous_index = 12'($urandom);
    return it;
  endfunction

  task automatic send_item(input in_t it, output out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    want = fat_op_result(it);
    pending_results.push_back(want);
    op_seen[it.opcode]++;
    status_seen[want.status]++;
    items_sent++;
    cycle_budget += 4 * (op_span + 32 + MAX_GAP + MAX_STALL);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DATA_BLOCKS) dbc_model = value;
    else if (idx == CFG_FAT_BLOCKS) fbc_model = value[7:0];
  endtask

  task automatic set_config(int dbc, int fbc);
    wait_results_drained();
    repeat (4) @(posedge clk);
    cycle_budget += 2000;
    cfg_write(CFG_DATA_BLOCKS, 13'(dbc));
    cfg_write(CFG_FAT_BLOCKS, 13'(fbc));
    cfg_valid <= 1'b0;
    config_count++;
  endtask

  // Result monitor
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending (status %0d)", out_data.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("found_index", want.found_index, out_data.found_index);
        check_field("absolute_block", want.absolute_block, out_data.absolute_block);
        check_field("read_value", want.read_value, out_data.read_value);
        check_field("tally", want.tally, out_data.tally);
        check_field("chain_ended", want.chain_ended, out_data.chain_ended);
      end
    end
  end

  // Receiver back-pressure: the mode is redrawn at regular intervals
  int stall_clock = 0;
  int stall_mode = 0;
  int stall_run = 0;

  always @(posedge clk) begin
    stall_clock++;
    if (stall_clock % 300 == 0) stall_mode = $urandom_range(0, 2);
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: begin
          if ($urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            stall_run = $urandom_range(0, MAX_STALL - 1);
          end
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  initial begin : watchdog
    while (cycles <= cycle_budget) begin
      @(posedge clk);
      cycles++;
    end
    $error("timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  // Tests
  task automatic test_table_load();
    out_t res;
    int i;
    for (i = 0; i < FAT_N; i++)
      send_item(make_item(OP_WRITE, 16'(i), (i == 0) ? END_OF_CHAIN : FREE_ENTRY,
                          24'($urandom), 1'($urandom), 12'($urandom)), res);
  endtask

  task automatic test_entry_access();
    out_t res;
    send_item(make_item(OP_WRITE, 16'd4095, 16'hFFFE, '0, 1'b0, '0), res);
    send_item(make_item(OP_READ, 16'd4095, '0, '0, 1'b0, '0), res);
    send_item(make_item(OP_WRITE, 16'hFFFF, 16'h1234, '0, 1'b0, '0), res);
    send_item(make_item(OP_READ, 16'd4096, '0, '0, 1'b0, '0), res);
    send_item(make_item(OP_WRITE, 16'd4095, FREE_ENTRY, 24'hFFFFFF, 1'b1, 12'hFFF), res);
  endtask

  task automatic test_walk_cases();
    out_t res;
    send_item(make_item(OP_WRITE, 16'd10, 16'd11, '0, 1'b0, '0), res);
    send_item(make_item(OP_WRITE, 16'd11, END_OF_CHAIN, '0, 1'b0, '0), res);
    send_item(make_item(OP_WRITE, 16'd12, 16'hF000, '0, 1'b0, '0), res);
    send_item(make_item(OP_WALK, 16'd10, '0, 24'h000FFF, 1'b0, '0), res);
    send_item(make_item(OP_WALK, 16'd10, '0, 24'hFFFFFF, 1'b0, '0), res);
    send_item(make_item(OP_WALK, 16'd12, '0, 24'h003000, 1'b0, '0), res);
    send_item(make_item(OP_WALK, END_OF_CHAIN, '0, 24'h001000, 1'b0, '0), res);
    send_item(make_item(OP_WALK, 16'h1000, '0, 24'h001000, 1'b0, '0), res);
  endtask

  task automatic test_alloc_cases();
    out_t res;
    // append to the chain at 10, then an allocation linked into itself
    send_item(make_item(OP_ALLOC, '0, '0, '0, 1'b1, 12'd11), res);
    send_item(make_item(OP_ALLOC, '0, '0, '0, 1'b1, 12'd2), res);
  endtask

  task automatic test_free_cases();
    out_t res;
    send_item(make_item(OP_FREE, 16'd10, '0, '0, 1'b0, '0), res);
    send_item(make_item(OP_FREE, END_OF_CHAIN, '0, '0, 1'b0, '0), res);
    send_item(make_item(OP_FREE, 16'd12, '0, '0, 1'b0, '0), res);
    // chain into a free entry with entry 0 free runs to the loop limit
    send_item(make_item(OP_WRITE, 16'd0, FREE_ENTRY, '0, 1'b0, '0), res);
    send_item(make_item(OP_FREE, 16'd3, '0, '0, 1'b0, '0), res);
    send_item(make_item(OP_WRITE, 16'd0, END_OF_CHAIN, '0, 1'b0, '0), res);
  endtask

  task automatic test_count_and_unused();
    in_t it;
    out_t res;
    send_item(make_item(OP_COUNT, '0, '0, '0, 1'b0, '0), res);
    it = random_item();
    it.opcode = OP_UNUSED_6;
    send_item(it, res);
    it = random_item();
    it.opcode = OP_UNUSED_7;
    send_item(it, res);
  endtask

  task automatic test_config_extremes();
    out_t res;
    set_config(1, 255);
    send_item(make_item(OP_ALLOC, '0, '0, '0, 1'b1, 12'd5), res);
    send_item(make_item(OP_COUNT, '0, '0, '0, 1'b0, '0), res);
    send_item(make_item(OP_WALK, 16'd2, '0, '0, 1'b0, '0), res);
    set_config(8191, 1);
    send_item(make_item(OP_COUNT, '0, '0, '0, 1'b0, '0), res);
  endtask

  task automatic run_file_traffic(int n_items);
    in_t it;
    out_t res;
    int k;
    int r;
    int f;
    int steps;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      it = random_item();
      if (file_head.size() == 0 && r >= 35 && r < 72) r = 0;
      if ((file_head.size() > 24 || node_total > 120) && r < 35) r = 60;
      if (r < 35) begin
        it.opcode = OP_ALLOC;
        f = -1;
        if (file_head.size() == 0 || $urandom_range(0, 3) == 0) begin
          it.link_enable = 1'b0;
        end else begin
          f = $urandom_range(0, file_head.size() - 1);
          it.link_enable = 1'b1;
          it.previous_index = 12'(file_tail[f]);
        end
        send_item(it, res);
        if (res.status == ST_OK) begin
          node_total++;
          if (f < 0) begin
            file_head.push_back(int'(res.found_index));
            file_tail.push_back(int'(res.found_index));
            file_len.push_back(1);
          end else begin
            file_tail[f] = int'(res.found_index);
            file_len[f]++;
          end
        end
      end else if (r < 60) begin
        f = $urandom_range(0, file_head.size() - 1);
        steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, file_len[f] + 1);
        it.opcode = OP_WALK;
        it.entry_index = 16'(file_head[f]);
        it.byte_offset = {12'(steps), it.byte_offset[11:0]};
        send_item(it, res);
      end else if (r < 72) begin
        f = $urandom_range(0, file_head.size() - 1);
        it.opcode = OP_FREE;
        it.entry_index = 16'(file_head[f]);
        node_total -= file_len[f];
        file_head.delete(f);
        file_tail.delete(f);
        file_len.delete(f);
        send_item(it, res);
      end else if (r < 78) begin
        it.opcode = OP_READ;
        it.entry_index = 16'($urandom_range(0, FAT_N - 1));
        send_item(it, res);
      end else if (r < 82) begin
        it.opcode = (r % 2 == 0) ? OP_WRITE : OP_READ;
        if (it.entry_index == 16'd0) it.entry_index = 16'd1;
        send_item(it, res);
      end else if (r < 85) begin
        it.opcode = OP_COUNT;
        send_item(it, res);
      end else if (r < 88) begin
        it.opcode = OP_WALK;
        send_item(it, res);
      end else if (r < 90) begin
        it.opcode = OP_FREE;
        it.entry_index = 16'($urandom_range(FAT_N, 16'hFFFF));
        send_item(it, res);
      end else if (r < 96) begin
        it.opcode = ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
        send_item(it, res);
      end else begin
        it.opcode = OP_ALLOC;
        send_item(it, res);
      end
      // keep entry 0 as end of chain so stray chains stay short
      if (fat_model[0] != END_OF_CHAIN) begin
        it = random_item();
        it.opcode = OP_WRITE;
        it.entry_index = 16'd0;
        it.entry_data = END_OF_CHAIN;
        send_item(it, res);
      end
      if ($urandom_range(0, 99) == 0) wait_results_drained();
    end
  endtask

  task automatic test_file_traffic();
    set_config(4096, 2);
    run_file_traffic(300);
    set_config(8191, 255);
    run_file_traffic(250);
    set_config(64, 1);
    run_file_traffic(250);
    set_config(1, 128);
    run_file_traffic(100);
    set_config($urandom_range(2, 1000), $urandom_range(1, 255));
    run_file_traffic(300);
    set_config(4096, 2);
    run_file_traffic(100);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_table_load();
    test_entry_access();
    test_walk_cases();
    test_alloc_cases();
    test_free_cases();
    test_count_and_unused();
    test_config_extremes();
    test_file_traffic();
    wait_results_drained();
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    $display("Covered %0d transfers: %0d writes, %0d reads, %0d walks, %0d allocs, %0d frees,",
             items_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
    $display("  %0d counts, %0d unused ops; status ok/no-free/bad/loop %0d/%0d/%0d/%0d; %0d configs",
             op_seen[5], op_seen[6] + op_seen[7], status_seen[0], status_seen[1],
             status_seen[2], status_seen[3], config_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/fce_pkg.sv
rtl/fat_chain_engine_core.sv
tb/tb_fat_chain_engine_core.sv
